>>> src/epfat_pkg.sv
// Package for the epoch-to-FAT timestamp converter: stage count, bus widths,
// the exact reciprocal constants used for constant division, and small tables.
// Has no dependencies; imported by epoch_to_fat_timestamp.
package epfat_pkg;

  localparam int NUM_STAGES  = 14;
  localparam int IN_W        = 53;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // Microseconds to seconds: drop 6 bits, then divide by 5^6 in two chunks.
  localparam logic [13:0] US_DIV    = 14'd15625;
  localparam logic [30:0] RECIP_HI  = 31'd1125899907;  // ceil(2^44 / 15625)
  localparam int          SHIFT_HI  = 44;
  localparam logic [31:0] RECIP_LO  = 32'd2251799814;  // ceil(2^45 / 15625)
  localparam int          SHIFT_LO  = 45;

  // Sub-second microseconds to hundredths.
  localparam logic [20:0] RECIP_CS  = 21'd1717987;     // ceil(2^34 / 10000)
  localparam int          SHIFT_CS  = 34;
  localparam logic [7:0]  ODD_SEC_CS = 8'd100;

  // Seconds to days: drop 7 bits, then divide by 675.
  localparam logic [9:0]  DAY_DIV   = 10'd675;
  localparam logic [27:0] RECIP_DAY = 28'd203613265;   // ceil(2^37 / 675)
  localparam int          SHIFT_DAY = 37;

  // Seconds of day to minutes, minutes to hours.
  localparam logic [17:0] RECIP_MIN = 18'd139811;      // ceil(2^23 / 60)
  localparam int          SHIFT_MIN = 23;
  localparam logic [11:0] RECIP_HR  = 12'd2185;        // ceil(2^17 / 60)
  localparam int          SHIFT_HR  = 17;
  localparam logic [5:0]  SIXTY     = 6'd60;

  // Civil calendar in 400-year eras, counted from 0000-03-01.
  localparam logic [19:0] DAYS_TO_0000 = 20'd719468;
  localparam logic [17:0] ERA_DAYS     = 18'd146097;
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;
  localparam logic [15:0] CENT_DAYS    = 16'd36524;
  localparam logic [18:0] RECIP_1460   = 19'd367720;   // ceil(2^29 / 1460)
  localparam int          SHIFT_1460   = 29;
  localparam logic [18:0] RECIP_365    = 19'd367720;   // ceil(2^27 / 365)
  localparam int          SHIFT_365    = 27;
  localparam logic [8:0]  YEAR_DAYS    = 9'd365;
  localparam logic [11:0] RECIP_153    = 12'd3427;     // ceil(2^19 / 153)
  localparam int          SHIFT_153    = 19;
  localparam logic [8:0]  ERA_YEARS    = 9'd400;
  localparam logic [11:0] FAT_BASE_YEAR = 12'd1980;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  // Number of whole eras in z (z stays below 8 eras).
  function automatic logic [2:0] era_of(input logic [19:0] z);
    logic [2:0] n;
    n = '0;
    for (int k = 1; k < 8; k++) begin
      if ({1'b0, z} >= 21'(k) * {3'd0, ERA_DAYS}) n = n + 3'd1;
    end
    return n;
  endfunction

  // Whole centuries of 36524 days in a day-of-era (0 to 4).
  function automatic logic [2:0] cent_of(input logic [17:0] doe);
    logic [2:0] n;
    n = '0;
    for (int k = 1; k < 5; k++) begin
      if (doe >= 18'(k) * {2'd0, CENT_DAYS}) n = n + 3'd1;
    end
    return n;
  endfunction

  // Whole centuries in a year-of-era below 400.
  function automatic logic [1:0] yoe_cent(input logic [8:0] yoe);
    logic [1:0] n;
    n = '0;
    for (int k = 1; k < 4; k++) begin
      if (yoe >= 9'(k * 100)) n = n + 2'd1;
    end
    return n;
  endfunction

  // Day-of-year at which each March-based month starts: (153*mp + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/epoch_to_fat_timestamp.sv
// Converts microseconds since 1970-01-01 UTC into FAT date, time and centisecond words.
// Throughput: one transaction per cycle while the output is not stalled; a full stage
// holds only while the stage after it cannot move.
// Reset: rst clears the stage valid bits only; data registers are not reset.
// Uses epfat_pkg for reciprocal constants, calendar tables and the hms_t type.
module epoch_to_fat_timestamp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [52:0] micros_since_epoch, [55:53] zero fill
  input  logic [epfat_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [15:0] fat_date, [31:16] fat_time, [39:32] centiseconds
  output logic [epfat_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import epfat_pkg::*;

  // Stage valid bits and per-stage advance. A stage loads when it is empty or
  // when the stage after it is moving, so bubbles are squeezed out and a stall
  // at the output only backs up as far as the pipeline is full.
  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] adv;

  assign adv[NUM_STAGES] = !vld[NUM_STAGES] || m_axis_tready;
  for (genvar i = 1; i < NUM_STAGES; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  assign s_axis_tready = adv[1];
  assign m_axis_tvalid = vld[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= s_axis_tvalid;
      for (int i = 2; i <= NUM_STAGES; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-4: seconds = us / 1e6. Shift out 6 bits, then long-divide the
  // remaining 47 bits by 15625 in two chunks (30 high bits, then the remainder
  // joined with 17 low bits). Each chunk: reciprocal multiply, then multiply
  // back to get the remainder.
  // ---------------------------------------------------------------------------
  logic [29:0] in_hi;
  logic [60:0] prod1;
  assign in_hi = s_axis_tdata[IN_W-1:23];
  assign prod1 = {31'd0, in_hi} * {30'd0, RECIP_HI};

  logic [16:0] p1_qa;
  logic [29:0] p1_hi;
  logic [22:0] p1_lo;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p1_qa <= prod1[SHIFT_HI +: 17];
      p1_hi <= in_hi;
      p1_lo <= s_axis_tdata[22:0];
    end
  end

  logic [29:0] back2;
  assign back2 = 30'({13'd0, p1_qa} * {16'd0, US_DIV});

  logic [16:0] p2_qa;
  logic [13:0] p2_ra;
  logic [22:0] p2_lo;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      p2_qa <= p1_qa;
      p2_ra <= 14'(p1_hi - back2);
      p2_lo <= p1_lo;
    end
  end

  logic [30:0] v3;
  logic [62:0] prod3;
  assign v3    = {p2_ra, p2_lo[22:6]};
  assign prod3 = {32'd0, v3} * {31'd0, RECIP_LO};

  logic [16:0] p3_qa;
  logic [16:0] p3_qb;
  logic [30:0] p3_v;
  logic [5:0]  p3_us;
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      p3_qa <= p2_qa;
      p3_qb <= prod3[SHIFT_LO +: 17];
      p3_v  <= v3;
      p3_us <= p2_lo[5:0];
    end
  end

  logic [30:0] back4;
  logic [13:0] rb4;
  assign back4 = 31'({14'd0, p3_qb} * {17'd0, US_DIV});
  assign rb4   = 14'(p3_v - back4);

  logic [33:0] p4_secs;
  logic [19:0] p4_sub;   // microseconds within the second
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      p4_secs <= {p3_qa, p3_qb};
      p4_sub  <= {rb4, p3_us};
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5-6: days = secs / 86400 as (secs >> 7) / 675, with the remainder
  // rebuilt by multiply-back. Hundredths come from the sub-second count in
  // parallel; odd seconds add 100 (86400 and 60 are even, so secs[0] decides).
  // ---------------------------------------------------------------------------
  logic [26:0] h5;
  logic [54:0] prod5;
  logic [40:0] prod_cs;
  assign h5      = p4_secs[33:7];
  assign prod5   = {28'd0, h5} * {27'd0, RECIP_DAY};
  assign prod_cs = {21'd0, p4_sub} * {20'd0, RECIP_CS};

  logic [16:0] p5_days;
  logic [26:0] p5_h;
  logic [6:0]  p5_slo;
  logic [6:0]  p5_csq;
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      p5_days <= prod5[SHIFT_DAY +: 17];
      p5_h    <= h5;
      p5_slo  <= p4_secs[6:0];
      p5_csq  <= prod_cs[SHIFT_CS +: 7];
    end
  end

  logic [26:0] back6;
  assign back6 = 27'({10'd0, p5_days} * {17'd0, DAY_DIV});

  logic [16:0] p6_rem;   // seconds within the day
  logic [19:0] p6_z;     // days since 0000-03-01
  logic [7:0]  p6_cs;
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      p6_rem <= {10'(p5_h - back6), p5_slo};
      p6_z   <= {3'd0, p5_days} + DAYS_TO_0000;
      p6_cs  <= {1'b0, p5_csq} + (p5_slo[0] ? ODD_SEC_CS : 8'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 7-9: split the second of day into hour, minute, second; find the era
  // and the day within it.
  // ---------------------------------------------------------------------------
  logic [34:0] prod7;
  assign prod7 = {18'd0, p6_rem} * {17'd0, RECIP_MIN};

  logic [16:0] p7_rem;
  logic [10:0] p7_totmin;
  logic [19:0] p7_z;
  logic [2:0]  p7_era;
  logic [7:0]  p7_cs;
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      p7_rem    <= p6_rem;
      p7_totmin <= prod7[SHIFT_MIN +: 11];
      p7_z      <= p6_z;
      p7_era    <= era_of(p6_z);
      p7_cs     <= p6_cs;
    end
  end

  logic [16:0] back8;
  logic [22:0] prod8;
  logic [19:0] era_base8;
  assign back8     = 17'({6'd0, p7_totmin} * {11'd0, SIXTY});
  assign prod8     = {12'd0, p7_totmin} * {11'd0, RECIP_HR};
  assign era_base8 = 20'({17'd0, p7_era} * {2'd0, ERA_DAYS});

  logic [5:0]  p8_sec;
  logic [4:0]  p8_hour;
  logic [10:0] p8_totmin;
  logic [17:0] p8_doe;
  logic [2:0]  p8_era;
  logic [7:0]  p8_cs;
  always_ff @(posedge clk) begin
    if (adv[8]) begin
      p8_sec    <= 6'(p7_rem - back8);
      p8_hour   <= prod8[SHIFT_HR +: 5];
      p8_totmin <= p7_totmin;
      p8_doe    <= 18'(p7_z - era_base8);
      p8_era    <= p7_era;
      p8_cs     <= p7_cs;
    end
  end

  logic [10:0] back9;
  logic [36:0] prod9;
  assign back9 = 11'({6'd0, p8_hour} * {5'd0, SIXTY});
  assign prod9 = {19'd0, p8_doe} * {18'd0, RECIP_1460};

  hms_t        p9_hms;
  logic [17:0] p9_doe;
  logic [6:0]  p9_leap4;   // doe / 1460
  logic [2:0]  p9_cent;    // doe / 36524
  logic        p9_last;    // last day of the era
  logic [2:0]  p9_era;
  logic [7:0]  p9_cs;
  always_ff @(posedge clk) begin
    if (adv[9]) begin
      p9_hms.hour   <= p8_hour;
      p9_hms.minute <= 6'(p8_totmin - back9);
      p9_hms.second <= p8_sec;
      p9_doe        <= p8_doe;
      p9_leap4      <= prod9[SHIFT_1460 +: 7];
      p9_cent       <= cent_of(p8_doe);
      p9_last       <= (p8_doe == ERA_LAST_DAY);
      p9_era        <= p8_era;
      p9_cs         <= p8_cs;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 10-13: year of era, day of year, March-based month.
  // ---------------------------------------------------------------------------
  hms_t        p10_hms;
  logic [17:0] p10_t;
  logic [17:0] p10_doe;
  logic [2:0]  p10_era;
  logic [7:0]  p10_cs;
  always_ff @(posedge clk) begin
    if (adv[10]) begin
      p10_hms <= p9_hms;
      p10_t   <= p9_doe - {11'd0, p9_leap4} + {15'd0, p9_cent} - {17'd0, p9_last};
      p10_doe <= p9_doe;
      p10_era <= p9_era;
      p10_cs  <= p9_cs;
    end
  end

  logic [36:0] prod11;
  assign prod11 = {19'd0, p10_t} * {18'd0, RECIP_365};

  hms_t        p11_hms;
  logic [8:0]  p11_yoe;
  logic [17:0] p11_doe;
  logic [2:0]  p11_era;
  logic [7:0]  p11_cs;
  always_ff @(posedge clk) begin
    if (adv[11]) begin
      p11_hms <= p10_hms;
      p11_yoe <= prod11[SHIFT_365 +: 9];
      p11_doe <= p10_doe;
      p11_era <= p10_era;
      p11_cs  <= p10_cs;
    end
  end

  logic [17:0] yoe_days12;
  logic [17:0] doy12;
  assign yoe_days12 = 18'({9'd0, p11_yoe} * {9'd0, YEAR_DAYS});
  assign doy12 = p11_doe - yoe_days12 - {11'd0, p11_yoe[8:2]}
               + {16'd0, yoe_cent(p11_yoe)};

  hms_t        p12_hms;
  logic [8:0]  p12_yoe;
  logic [8:0]  p12_doy;
  logic [2:0]  p12_era;
  logic [7:0]  p12_cs;
  always_ff @(posedge clk) begin
    if (adv[12]) begin
      p12_hms <= p11_hms;
      p12_yoe <= p11_yoe;
      p12_doy <= doy12[8:0];
      p12_era <= p11_era;
      p12_cs  <= p11_cs;
    end
  end

  logic [10:0] num13;
  logic [22:0] prod13;
  assign num13  = {2'd0, p12_doy} * 11'd5 + 11'd2;
  assign prod13 = {12'd0, num13} * {11'd0, RECIP_153};

  hms_t        p13_hms;
  logic [8:0]  p13_yoe;
  logic [8:0]  p13_doy;
  logic [3:0]  p13_mp;
  logic [2:0]  p13_era;
  logic [7:0]  p13_cs;
  always_ff @(posedge clk) begin
    if (adv[13]) begin
      p13_hms <= p12_hms;
      p13_yoe <= p12_yoe;
      p13_doy <= p12_doy;
      p13_mp  <= prod13[SHIFT_153 +: 4];
      p13_era <= p12_era;
      p13_cs  <= p12_cs;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 14: day of month, civil month, year (January and February belong to
  // the next year), then pack the FAT words into the output register.
  // ---------------------------------------------------------------------------
  logic [8:0]  mday14;
  logic [3:0]  month14;
  logic [11:0] year14;
  logic [6:0]  yf14;
  logic [15:0] date14;
  logic [15:0] time14;

  always_comb begin
    mday14  = p13_doy - month_start(p13_mp) + 9'd1;
    month14 = (p13_mp < 4'd10) ? p13_mp + 4'd3 : p13_mp - 4'd9;
    year14  = {3'd0, p13_yoe} + 12'({9'd0, p13_era} * {3'd0, ERA_YEARS})
            + {11'd0, (month14 <= 4'd2)};
    yf14    = 7'(year14 - FAT_BASE_YEAR);
    date14  = {yf14, month14, mday14[4:0]};
    time14  = {p13_hms.hour, p13_hms.minute, p13_hms.second[5:1]};
  end

  always_ff @(posedge clk) begin
    if (adv[14]) begin
      m_axis_tdata <= {p13_cs, time14, date14};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input backpressure only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&vld))
    else $error("input stalled with an empty pipeline stage");

  // Reciprocal division by 1e6 leaves a proper sub-second remainder.
  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (p4_sub < 20'd1000000))
    else $error("sub-second remainder out of range");

  // Day split leaves a proper second-of-day.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (p6_rem < 17'd86400))
    else $error("second of day out of range");

  // Output fields stay in their calendar ranges.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39:32] <= 8'd199) && (m_axis_tdata[8:5] != 4'd0)
      && (m_axis_tdata[8:5] <= 4'd12) && (m_axis_tdata[4:0] != 5'd0)
      && (m_axis_tdata[31:27] <= 5'd23) && (m_axis_tdata[26:21] <= 6'd59))
    else $error("output field out of range");

endmodule

>>> verif/tb_epoch_to_fat_timestamp.sv
// Testbench for epoch_to_fat_timestamp: drives microsecond counts over the input stream and
// checks each FAT date, time and centisecond word against an in-bench calendar predictor.
// Depends on epfat_pkg and the epoch_to_fat_timestamp RTL only.
`timescale 1ns / 1ps

module tb_epoch_to_fat_timestamp;

  import epfat_pkg::*;

  localparam longint unsigned MICROS_MAX = (64'd1 << IN_W) - 64'd1;
  localparam int PHASE_A_END  = 450;   // sender idles lightly, receiver heavily
  localparam int PHASE_B_END  = 900;   // the other way round
  localparam int HOLD_AT      = 1100;  // start of the long receiver hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 40;

  // Laid out as on m_axis_tdata: fat_date in the low bits, centiseconds on top.
  typedef struct packed {
    logic [7:0]  centiseconds;
    logic [15:0] fat_time;
    logic [15:0] fat_date;
  } fat_stamp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [IN_W-1:0] pending_micros[$];
  fat_stamp_t      expected_stamps[$];
  int              n_accepted = 0;
  int              mismatch_count = 0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;

  epoch_to_fat_timestamp u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Convert microseconds since the epoch to the FAT words, gmtime style.
  function automatic fat_stamp_t predict_fat_stamp(input logic [IN_W-1:0] micros);
    longint unsigned secs, millis, days, sod, hour, minute, sec;
    longint unsigned z, era, doe, yoe, doy, mp, mday, month, year, cs;
    fat_stamp_t r;
    secs   = micros / 64'd1000000;
    millis = (micros / 64'd1000) % 64'd1000;
    days   = secs / 64'd86400;
    sod    = secs % 64'd86400;
    hour   = sod / 64'd3600;
    minute = (sod % 64'd3600) / 64'd60;
    sec    = sod % 64'd60;
    // Civil date from a day count, with eras of 400 years starting in March.
    z     = days + 64'd719468;
    era   = z / 64'd146097;
    doe   = z - era * 64'd146097;
    yoe   = (doe - doe / 64'd1460 + doe / 64'd36524 - doe / 64'd146096) / 64'd365;
    doy   = doe - (64'd365 * yoe + yoe / 64'd4 - yoe / 64'd100);
    mp    = (64'd5 * doy + 64'd2) / 64'd153;
    mday  = doy - (64'd153 * mp + 64'd2) / 64'd5 + 64'd1;
    month = (mp < 64'd10) ? mp + 64'd3 : mp - 64'd9;
    year  = yoe + era * 64'd400 + ((month <= 64'd2) ? 64'd1 : 64'd0);
    cs    = millis / 64'd10 + ((sec % 64'd2 == 64'd1) ? 64'd100 : 64'd0);
    r.fat_date     = {7'((year - 64'd1980) & 64'h7f), 4'(month), 5'(mday)};
    r.fat_time     = {5'(hour), 6'(minute), 5'(sec / 64'd2)};
    r.centiseconds = 8'(cs);
    return r;
  endfunction

  // Build a microsecond count from a civil UTC date and time (years from 1970 on).
  function automatic logic [IN_W-1:0] micros_at(input int yr, input int mo, input int dd,
                                                input int hh, input int mi, input int ss,
                                                input longint unsigned frac_us);
    longint unsigned yy, era, yoe, doy, doe, days;
    yy   = longint'(yr) - ((mo <= 2) ? 1 : 0);
    era  = yy / 400;
    yoe  = yy - era * 400;
    doy  = (153 * longint'((mo > 2) ? mo - 3 : mo + 9) + 2) / 5 + longint'(dd) - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    return IN_W'(((days * 86400 + longint'(hh) * 3600 + longint'(mi) * 60 + longint'(ss))
                  * 1000000) + frac_us);
  endfunction

  function automatic int send_idle_pct(input int n);
    if (n < PHASE_A_END) return 35;
    if (n < PHASE_B_END) return 82;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int n);
    if (n < PHASE_A_END) return 82;
    if (n < PHASE_B_END) return 35;
    return 0;
  endfunction

  // Driver: hold an offered transaction until taken, then offer the next or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_stamps.push_back(predict_fat_stamp(s_axis_tdata[IN_W-1:0]));
        void'(pending_micros.pop_front());
        n_accepted <= n_accepted + 1;
      end
      if (pending_micros.size() != 0 && $urandom_range(99) >= send_idle_pct(n_accepted)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(pending_micros[0]);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output transaction with the oldest prediction, and
  // drive tready with random stalls plus one long hold-off to back up the pipe.
  always @(posedge clk) begin
    fat_stamp_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_stamps.size() == 0) begin
          $error("result with no prediction waiting: %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_stamps.pop_front();
          if (got.fat_date !== want.fat_date) begin
            $error("fat_date: expected %h, got %h", want.fat_date, got.fat_date);
            mismatch_count++;
          end
          if (got.fat_time !== want.fat_time) begin
            $error("fat_time: expected %h, got %h", want.fat_time, got.fat_time);
            mismatch_count++;
          end
          if (got.centiseconds !== want.centiseconds) begin
            $error("centiseconds: expected %0d, got %0d", want.centiseconds,
                   got.centiseconds);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_left     <= HOLD_CYCLES;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct(n_accepted));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    longint signed   v;
    longint unsigned offset;
    int              sel, yr, mo;

    // Directed: field extremes, year wrap on both sides, leap rules, truncation.
    pending_micros.push_back('0);
    pending_micros.push_back(IN_W'(MICROS_MAX));
    pending_micros.push_back(IN_W'(MICROS_MAX >> 1));
    pending_micros.push_back(IN_W'((MICROS_MAX >> 1) + 1));
    pending_micros.push_back(IN_W'(64'd999999));
    pending_micros.push_back(IN_W'(64'd1000000));
    pending_micros.push_back(IN_W'(64'd86400000000 - 1));
    pending_micros.push_back(IN_W'(64'd86400000000));
    pending_micros.push_back(micros_at(1970, 1, 1, 0, 0, 1, 999999));
    pending_micros.push_back(micros_at(1979, 12, 31, 23, 59, 59, 999999));
    pending_micros.push_back(micros_at(1980, 1, 1, 0, 0, 0, 0));
    pending_micros.push_back(micros_at(1980, 1, 1, 0, 0, 0, 9999));
    pending_micros.push_back(micros_at(1999, 12, 31, 23, 59, 59, 990000));
    pending_micros.push_back(micros_at(2000, 2, 29, 12, 34, 57, 123456));
    pending_micros.push_back(micros_at(2000, 3, 1, 0, 0, 0, 0));
    pending_micros.push_back(micros_at(2001, 9, 9, 1, 46, 39, 999999));
    pending_micros.push_back(micros_at(2023, 12, 31, 23, 59, 59, 999999));
    pending_micros.push_back(micros_at(2024, 2, 29, 23, 59, 59, 999000));
    pending_micros.push_back(micros_at(2100, 2, 28, 23, 59, 59, 990000));
    pending_micros.push_back(micros_at(2100, 3, 1, 0, 0, 0, 10000));
    pending_micros.push_back(micros_at(2107, 12, 31, 23, 59, 58, 500000));
    pending_micros.push_back(micros_at(2108, 1, 1, 0, 0, 0, 0));
    pending_micros.push_back(micros_at(2200, 6, 15, 7, 8, 9, 876543));
    pending_micros.push_back(micros_at(2255, 1, 1, 0, 0, 0, 0));

    // Random: mostly the whole 53-bit range, plus counts just around month
    // starts and counts inside the unwrapped FAT year range.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        pending_micros.push_back(IN_W'({$urandom, $urandom}));
      end else if (sel < 85) begin
        yr     = $urandom_range(2254, 1970);
        mo     = $urandom_range(12, 1);
        offset = $urandom_range(4000000);
        v      = longint'(micros_at(yr, mo, 1, 0, 0, 0, 0)) + longint'(offset) - 2000000;
        if (v < 0) v = -v;
        pending_micros.push_back(IN_W'(v));
      end else begin
        offset = {$urandom, $urandom} % (micros_at(2108, 1, 1, 0, 0, 0, 0) -
                                         micros_at(1980, 1, 1, 0, 0, 0, 0));
        pending_micros.push_back(micros_at(1980, 1, 1, 0, 0, 0, 0) + IN_W'(offset));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_micros.size() != 0 || s_axis_tvalid || expected_stamps.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
src/epfat_pkg.sv
src/epoch_to_fat_timestamp.sv
verif/tb_epoch_to_fat_timestamp.sv
